// File: sv/rtp_pkg.sv
// rtp_pkg: shared types and constants for the rectangular-to-polar CORDIC core.
// Holds the request/result payload structs, the per-cell stage record and the
// arctangent table. No dependencies.
package rtp_pkg;

    localparam int SAMPLE_W = 16;                       // width of every payload field
    localparam int GUARD_W  = 16;                       // fraction bits below the sample
    localparam int DATA_W   = SAMPLE_W + GUARD_W + 3;   // x/y path: sign, growth, guard
    localparam int ANGLE_W  = 32;                       // angle accumulator, full turn = 2^32
    localparam int MAX_STEPS = 32;                      // depth of the arctangent table

    localparam logic [31:0]        GAIN_Q32  = 32'd2608131496;  // CORDIC gain compensation
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(1) << (ANGLE_W - 1);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:MAX_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] real_part;
        logic signed [SAMPLE_W-1:0] imag_part;
    } sample_t;

    typedef struct packed {
        logic        [SAMPLE_W-1:0] magnitude;
        logic signed [SAMPLE_W-1:0] angle;
    } polar_t;

    // one slot of the rotation chain
    typedef struct packed {
        logic                       valid;
        logic                       zero;   // request was the origin
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   y;
        logic        [ANGLE_W-1:0]  z;
    } cordic_stage_t;

endpackage

// File: sv/rectangular_to_polar_core.sv
// rectangular_to_polar_core: top level of the pipelined CORDIC vectoring core.
// Depends on rtp_pkg, rtp_cordic_cell and rtp_gain_scale.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+----------------------------------------
//  request   | start, busy, sample   | taken on a clock edge with start & !busy
//  result    | done, result          | done high one cycle, no back-pressure
//
// Timing: one request per cycle. Each result passes the quadrant fold register,
// the register of every rotation cell, then the gain multiply register and the
// final rounding register.
// busy never rises: the chain is a pure pipeline with no shared unit.
// Reset clears the valid bits of every stage; requests in flight are dropped.
// The result side cannot stall, so nothing inside ever holds.
module rectangular_to_polar_core #(
    parameter int ROTATION_STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rtp_pkg::sample_t sample,
    output logic             done,
    output rtp_pkg::polar_t  result
);
    import rtp_pkg::*;

    localparam int LATENCY = ROTATION_STEPS + 3;

    logic signed [DATA_W-1:0] re_ext;
    logic signed [DATA_W-1:0] im_ext;
    logic                     re_neg;
    cordic_stage_t            fold_next;
    cordic_stage_t            fold_reg;

    // stage_q[i] feeds cell i; the last entry feeds the gain stage
    cordic_stage_t            stage_q [0:ROTATION_STEPS];

    assign busy = 1'b0;

    // Fold into the right half plane: a negative real part negates both
    // components and starts the accumulator at a half turn. Scale up by the
    // guard bits so the floor shifts of the cells keep their precision.
    always_comb
    begin
        re_ext = {{(DATA_W - SAMPLE_W){sample.real_part[SAMPLE_W-1]}}, sample.real_part};
        im_ext = {{(DATA_W - SAMPLE_W){sample.imag_part[SAMPLE_W-1]}}, sample.imag_part};
        re_neg = sample.real_part[SAMPLE_W-1];

        fold_next.valid = start & ~busy;
        fold_next.zero  = (sample.real_part == '0) && (sample.imag_part == '0);
        fold_next.x     = (re_neg ? -re_ext : re_ext) <<< GUARD_W;
        fold_next.y     = (re_neg ? -im_ext : im_ext) <<< GUARD_W;
        fold_next.z     = re_neg ? HALF_TURN : '0;
    end

    // fold stage: advance every cycle, clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_reg <= '0;
        else
            fold_reg <= fold_next;
    end

    assign stage_q[0] = fold_reg;

    // Row of micro-rotation cells; cell i shifts by i and uses atan(2^-i).
    for (genvar g = 0; g < ROTATION_STEPS; g++)
    begin : g_cell
        rtp_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage_q[g]),
            .stage_out (stage_q[g+1])
        );
    end

    // Gain compensation of the residual x and rounding of the angle.
    rtp_gain_scale u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (stage_q[ROTATION_STEPS]),
        .done     (done),
        .result   (result)
    );

    // A result only ever follows a request that has passed through the whole pipeline.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching request");

    // The fold leaves x in the right half plane.
    a_fold_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        stage_q[0].valid |-> !stage_q[0].x[DATA_W-1])
        else $error("fold produced a negative x");

    // Vectoring only grows x, so any nonzero request ends with x above zero.
    a_final_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_q[ROTATION_STEPS].valid && !stage_q[ROTATION_STEPS].zero)
            |-> (!stage_q[ROTATION_STEPS].x[DATA_W-1] && (stage_q[ROTATION_STEPS].x != '0)))
        else $error("rotation chain ended with x not positive");

endmodule

// File: sv/rtp_cordic_cell.sv
// rtp_cordic_cell: one registered CORDIC vectoring micro-rotation.
// Depends on rtp_pkg (cordic_stage_t, ATAN_TURNS).
module rtp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtp_pkg::cordic_stage_t stage_in,
    output rtp_pkg::cordic_stage_t stage_out
);
    import rtp_pkg::*;

    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    cordic_stage_t            out_reg;
    cordic_stage_t            out_next;

    always_comb
    begin
        out_next = stage_in;
        dx       = stage_in.x >>> STEP;
        dy       = stage_in.y >>> STEP;
        // rotate clockwise when y is zero or positive
        if (!stage_in.y[DATA_W-1])
        begin
            out_next.x = stage_in.x + dy;
            out_next.y = stage_in.y - dx;
            out_next.z = stage_in.z + ATAN_TURNS[STEP];
        end
        else
        begin
            out_next.x = stage_in.x - dy;
            out_next.y = stage_in.y + dx;
            out_next.z = stage_in.z - ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else
            out_reg <= out_next;
    end

    assign stage_out = out_reg;

endmodule

// File: sv/rtp_gain_scale.sv
// rtp_gain_scale: two-stage gain compensation, rounding and saturation of the
// magnitude, and rounding of the angle. Depends on rtp_pkg.
module rtp_gain_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtp_pkg::cordic_stage_t stage_in,
    output logic                   done,
    output rtp_pkg::polar_t        result
);
    import rtp_pkg::*;

    localparam int UX_W      = DATA_W - 1;
    localparam int LO_W      = (UX_W + 1) / 2;
    localparam int HI_W      = UX_W - LO_W;
    localparam int PLO_W     = LO_W + 32;
    localparam int PHI_W     = HI_W + 32;
    localparam int SUM_W     = UX_W + 32 + 1;
    localparam int MAG_SHIFT = 32 + GUARD_W;
    localparam int MAGW_W    = SUM_W - MAG_SHIFT;

    localparam logic [SUM_W-1:0]   MAG_ROUND   = SUM_W'(1) << (MAG_SHIFT - 1);
    localparam logic [ANGLE_W-1:0] ANGLE_ROUND = ANGLE_W'(1) << (ANGLE_W - 1 - SAMPLE_W);

    logic [UX_W-1:0]     ux;
    logic [ANGLE_W-1:0]  ang_full;
    logic [PLO_W-1:0]    plo_next;
    logic [PHI_W-1:0]    phi_next;
    logic [SAMPLE_W-1:0] ang_next;

    logic                s1_valid_reg;
    logic [PLO_W-1:0]    plo_reg;
    logic [PHI_W-1:0]    phi_reg;
    logic [SAMPLE_W-1:0] ang_reg;

    logic [SUM_W-1:0]    sum;
    logic [MAGW_W-1:0]   mag_wide;
    polar_t              result_next;
    polar_t              result_reg;
    logic                done_reg;

    // stage 1: split products of the clamped x by the gain, round the angle
    always_comb
    begin
        ux       = stage_in.x[DATA_W-1] ? '0 : stage_in.x[UX_W-1:0];
        plo_next = PLO_W'(ux[LO_W-1:0]) * PLO_W'(GAIN_Q32);
        phi_next = PHI_W'(ux[UX_W-1:LO_W]) * PHI_W'(GAIN_Q32);
        ang_full = stage_in.z + ANGLE_ROUND;
        ang_next = stage_in.zero ? '0 : ang_full[ANGLE_W-1 -: SAMPLE_W];
    end

    // stage 2: recombine, round half up, saturate
    always_comb
    begin
        sum      = (SUM_W'(phi_reg) << LO_W) + SUM_W'(plo_reg) + MAG_ROUND;
        mag_wide = sum[SUM_W-1:MAG_SHIFT];
        if (|mag_wide[MAGW_W-1:SAMPLE_W])
            result_next.magnitude = '1;
        else
            result_next.magnitude = mag_wide[SAMPLE_W-1:0];
        result_next.angle = ang_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= stage_in.valid;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        ang_reg    <= ang_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
